// ===== sv/modbus_tcp_request_parser_assert.svh =====
// Assertion macros for the Modbus TCP request parser
`ifndef MODBUS_TCP_REQUEST_PARSER_ASSERT_SVH
`define MODBUS_TCP_REQUEST_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MBTCP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mbtcp assertion failed");
`define MBTCP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mbtcp assertion failed");
`else
`define MBTCP_ASSERT(name, prop)
`define MBTCP_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== sv/mbtcp_pkg.sv =====
package mbtcp_pkg;

  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [POS_W-1:0] POS_FUNC_CODE = 9'd7;
  localparam logic [POS_W-1:0] POS_VALUE_LOW = 9'd11;
  localparam logic [POS_W-1:0] POS_COUNT = 9'd12;
  localparam logic [POS_W-1:0] POS_DATA = 9'd13;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_SINGLE_WRITE = 1'b0;
  localparam logic REG_MULTI_WRITE = 1'b1;

  localparam logic [7:0] SINGLE_WRITE_RESET = 8'd6;
  localparam logic [7:0] MULTI_WRITE_RESET = 8'd16;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [7:0]  length_low;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] value;
    logic [7:0]  byte_count;
    logic [15:0] data_word;
    logic [6:0]  word_index;
    logic        last;
  } result_t;

endpackage

// ===== sv/mbtcp_if.sv =====
interface mbtcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mbtcp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [7:0]  length_low;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] value;
  logic [7:0]  byte_count;
  logic [15:0] data_word;
  logic [6:0]  word_index;
  logic        last;

  modport source (
    output valid, output kind, output transaction_id, output protocol_id,
    output length_low, output unit_id, output function_code, output start_address,
    output value, output byte_count, output data_word, output word_index,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input transaction_id, input protocol_id,
    input length_low, input unit_id, input function_code, input start_address,
    input value, input byte_count, input data_word, input word_index,
    input last, output ready
  );
endinterface

// ===== sv/modbus_tcp_request_parser.sv =====
// A result is registered into od (or sd while od stalls) from the byte that causes it.
// Throughput: one byte per cycle while sd is empty; the parse is one pass of logic.
// A two-entry output buffer keeps bytes flowing while one result waits to be taken.
// Reset (rst, synchronous) clears the buffer, the byte position and the word count,
// restores the function code registers, and leaves the parser waiting for a frame start.
module modbus_tcp_request_parser #(
  parameter int unsigned MAX_REGS = 124
) (
  input  logic                             clk,
  input  logic                             rst,
  mbtcp_byte_if.sink                       byte_in,
  mbtcp_result_if.source                   result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbtcp_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam logic [15:0] MAX_COUNT = 16'(MAX_REGS);
  localparam logic [mbtcp_pkg::POS_W-1:0] POS_LIMIT =
    mbtcp_pkg::POS_W'(13 + 2 * MAX_REGS);

  logic [7:0] single_write_code;
  logic [7:0] multi_write_code;

  logic [mbtcp_pkg::POS_W-1:0] pos;
  logic [mbtcp_pkg::POS_W-1:0] pos_next;
  logic                        done;
  logic                        done_next;
  logic [6:0]                  words;
  logic [6:0]                  words_next;
  logic [7:0]                  hold;

  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [7:0]  length_low;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [7:0]  value_high;
  logic [7:0]  value_low;

  mbtcp_pkg::result_t res;
  logic               res_valid;
  mbtcp_pkg::result_t od;
  logic               ov;
  mbtcp_pkg::result_t sd;
  logic               sv;

  logic                        accept;
  logic                        pop;
  logic [7:0]                  b;
  logic [mbtcp_pkg::POS_W-1:0] cur_pos;
  logic                        cur_done;
  logic [6:0]                  cur_words;
  logic                        is_multi;
  logic [15:0]                 count;
  logic                        no_words;
  logic                        word_last;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      mbtcp_pkg::REG_SINGLE_WRITE: prdata = {24'd0, single_write_code};
      mbtcp_pkg::REG_MULTI_WRITE:  prdata = {24'd0, multi_write_code};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      single_write_code <= mbtcp_pkg::SINGLE_WRITE_RESET;
      multi_write_code  <= mbtcp_pkg::MULTI_WRITE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        mbtcp_pkg::REG_SINGLE_WRITE: single_write_code <= pwdata[7:0];
        mbtcp_pkg::REG_MULTI_WRITE:  multi_write_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign byte_in.ready = !sv;
  assign accept = byte_in.valid && byte_in.ready;
  assign pop = ov && result.ready;
  assign b = byte_in.rx_byte;

  assign cur_pos   = byte_in.frame_start ? '0 : pos;
  assign cur_done  = byte_in.frame_start ? 1'b0 : done;
  assign cur_words = byte_in.frame_start ? '0 : words;

  assign is_multi  = (function_code != single_write_code) && (function_code == multi_write_code);
  assign count     = {value_high, value_low};
  assign no_words  = (count == 16'd0) || (count >= MAX_COUNT);
  assign word_last = (16'(cur_words) + 16'd1) >= count;

  always_comb begin
    res        = '0;
    res_valid  = 1'b0;
    done_next  = cur_done;
    words_next = cur_words;
    pos_next   = cur_pos;
    if (!cur_done) begin
      pos_next = (cur_pos != mbtcp_pkg::POS_MAX) ? cur_pos + 1'b1 : cur_pos;
      res.kind           = mbtcp_pkg::KIND_HEADER;
      res.transaction_id = transaction_id;
      res.protocol_id    = protocol_id;
      res.length_low     = length_low;
      res.unit_id        = unit_id;
      res.function_code  = function_code;
      res.start_address  = start_address;
      if (cur_pos == mbtcp_pkg::POS_VALUE_LOW && !is_multi) begin
        res.value = {value_high, b};
        res.last  = 1'b1;
        res_valid = 1'b1;
        done_next = 1'b1;
      end else if (cur_pos == mbtcp_pkg::POS_COUNT) begin
        res.value      = count;
        res.byte_count = b;
        res.last       = no_words;
        res_valid      = 1'b1;
        done_next      = no_words;
      end else if (cur_pos >= mbtcp_pkg::POS_DATA && !cur_pos[0]) begin
        res            = '0;
        res.kind       = mbtcp_pkg::KIND_DATA;
        res.data_word  = {hold, b};
        res.word_index = cur_words;
        res.last       = word_last;
        res_valid      = 1'b1;
        words_next     = cur_words + 1'b1;
        done_next      = word_last;
      end
    end
  end

  // capture header bytes and the high byte of each data word; byte 4 is dropped, byte 12 is used directly
  always_ff @(posedge clk) begin
    if (accept && !cur_done) begin
      case (cur_pos)
        9'd0:  transaction_id[15:8] <= b;
        9'd1:  transaction_id[7:0] <= b;
        9'd2:  protocol_id[15:8] <= b;
        9'd3:  protocol_id[7:0] <= b;
        9'd5:  length_low <= b;
        9'd6:  unit_id <= b;
        mbtcp_pkg::POS_FUNC_CODE: function_code <= b;
        9'd8:  start_address[15:8] <= b;
        9'd9:  start_address[7:0] <= b;
        9'd10: value_high <= b;
        mbtcp_pkg::POS_VALUE_LOW: value_low <= b;
        default: ;
      endcase
      if (cur_pos >= mbtcp_pkg::POS_DATA && cur_pos[0]) begin
        hold <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      done  <= 1'b1;
      words <= '0;
    end else if (accept) begin
      pos   <= pos_next;
      done  <= done_next;
      words <= words_next;
    end
  end

  // two-entry output buffer: od is shown, sd takes a result while od is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (pop) begin
        sv <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!ov || pop) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (pop) begin
        od <= sd;
      end
    end else if (accept && res_valid) begin
      if (!ov || pop) begin
        od <= res;
      end else begin
        sd <= res;
      end
    end
  end

  assign result.valid          = ov;
  assign result.kind           = od.kind;
  assign result.transaction_id = od.transaction_id;
  assign result.protocol_id    = od.protocol_id;
  assign result.length_low     = od.length_low;
  assign result.unit_id        = od.unit_id;
  assign result.function_code  = od.function_code;
  assign result.start_address  = od.start_address;
  assign result.value          = od.value;
  assign result.byte_count     = od.byte_count;
  assign result.data_word      = od.data_word;
  assign result.word_index     = od.word_index;
  assign result.last           = od.last;

`include "modbus_tcp_request_parser_assert.svh"

  `MBTCP_ASSERT_ALWAYS(a_skid_behind_out, sv |-> ov)
  `MBTCP_ASSERT(a_data_header_zero, (ov && od.kind == mbtcp_pkg::KIND_DATA) |-> (od.transaction_id == 16'd0 && od.function_code == 8'd0 && od.value == 16'd0 && od.byte_count == 8'd0))
  `MBTCP_ASSERT(a_words_bounded, words < 7'(MAX_REGS))
  `MBTCP_ASSERT(a_pos_bounded, !done |-> (pos <= POS_LIMIT))

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REGS = 124;
  localparam int LIMIT = 1_000_000;
  localparam int ITEMS_PER_SETTING = 180;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mbtcp_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mbtcp_byte_if byte_in ();
  mbtcp_result_if result ();

  modbus_tcp_request_parser #(
    .MAX_REGS(MAX_REGS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // parser model state
  logic [7:0] single_code = mbtcp_pkg::SINGLE_WRITE_RESET;
  logic [7:0] multi_code = mbtcp_pkg::MULTI_WRITE_RESET;
  logic [8:0] byte_pos = '0;
  logic [7:0] hdr [0:12];
  logic [7:0] high_hold = '0;
  logic [6:0] words_sent = '0;
  bit frame_done = 1'b1;

  rx_item_t rx_pending[$];
  mbtcp_pkg::result_t predicted_results[$];

  bit in_flight;
  bit long_hold;
  int send_gap;
  int take_gap;
  int send_gap_pct;
  int take_gap_pct;
  int bytes_accepted;
  int items_queued;
  int frames_queued;
  int headers_checked;
  int words_checked;
  int mismatches;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mbtcp_pkg::result_t header_result(input logic [7:0] bcount,
                                                       input logic last);
    mbtcp_pkg::result_t r;
    r = '0;
    r.kind = mbtcp_pkg::KIND_HEADER;
    r.transaction_id = {hdr[0], hdr[1]};
    r.protocol_id = {hdr[2], hdr[3]};
    r.length_low = hdr[5];
    r.unit_id = hdr[6];
    r.function_code = hdr[7];
    r.start_address = {hdr[8], hdr[9]};
    r.value = {hdr[10], hdr[11]};
    r.byte_count = bcount;
    r.last = last;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output mbtcp_pkg::result_t r);
    logic [8:0] p;
    logic [15:0] cnt;
    logic [6:0] k;
    bit multi;
    bit none;
    bit last;
    bit emitted;
    r = '0;
    emitted = 1'b0;
    if (start) begin
      byte_pos = '0;
      frame_done = 1'b0;
      words_sent = '0;
      high_hold = '0;
      foreach (hdr[i]) hdr[i] = '0;
    end
    if (frame_done) return 1'b0;
    p = byte_pos;
    if (p <= mbtcp_pkg::POS_COUNT) hdr[p] = b;
    multi = (hdr[7] != single_code) && (hdr[7] == multi_code);
    cnt = {hdr[10], hdr[11]};
    if (p == mbtcp_pkg::POS_VALUE_LOW && !multi) begin
      r = header_result(8'h00, 1'b1);
      frame_done = 1'b1;
      emitted = 1'b1;
    end else if (p == mbtcp_pkg::POS_COUNT) begin
      none = (cnt == 0) || (int'(cnt) >= MAX_REGS);
      r = header_result(b, none);
      if (none) frame_done = 1'b1;
      emitted = 1'b1;
    end else if (p >= mbtcp_pkg::POS_DATA) begin
      if (p[0]) begin
        high_hold = b;
      end else begin
        k = words_sent;
        last = (int'(k) + 1 >= int'(cnt));
        r.kind = mbtcp_pkg::KIND_DATA;
        r.data_word = {high_hold, b};
        r.word_index = k;
        r.last = last;
        words_sent = k + 7'd1;
        if (last) frame_done = 1'b1;
        emitted = 1'b1;
      end
    end
    if (p != mbtcp_pkg::POS_MAX) byte_pos = p + 9'd1;
    return emitted;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // drive bytes
  always @(negedge clk) begin : byte_driver
    rx_item_t cur;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else if (!in_flight) begin
      if (send_gap > 0) begin
        send_gap--;
        byte_in.valid <= 1'b0;
      end else if (rx_pending.size() > 0) begin
        cur = rx_pending.pop_front();
        byte_in.valid <= 1'b1;
        byte_in.rx_byte <= cur.data;
        byte_in.frame_start <= cur.start;
        in_flight = 1'b1;
        if ($urandom_range(0, 99) < send_gap_pct) send_gap = pick_gap();
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // throttle results
  always @(negedge clk) begin
    if (rst || long_hold) begin
      result.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
      if ($urandom_range(0, 99) < take_gap_pct) take_gap = pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    mbtcp_pkg::result_t r;
    mbtcp_pkg::result_t want;
    cycle_count++;
    if (!rst) begin
      if (byte_in.valid && byte_in.ready) begin
        in_flight = 1'b0;
        bytes_accepted++;
        if (parse_byte(byte_in.rx_byte, byte_in.frame_start, r))
          predicted_results.push_back(r);
      end
      if (result.valid && result.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d word %0h last %0d",
                   $time, result.kind, result.data_word, result.last);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (want.kind == mbtcp_pkg::KIND_HEADER) headers_checked++;
          else words_checked++;
          check_field("kind", 16'(want.kind), 16'(result.kind));
          check_field("transaction_id", want.transaction_id, result.transaction_id);
          check_field("protocol_id", want.protocol_id, result.protocol_id);
          check_field("length_low", 16'(want.length_low), 16'(result.length_low));
          check_field("unit_id", 16'(want.unit_id), 16'(result.unit_id));
          check_field("function_code", 16'(want.function_code),
                      16'(result.function_code));
          check_field("start_address", want.start_address, result.start_address);
          check_field("value", want.value, result.value);
          check_field("byte_count", 16'(want.byte_count), 16'(result.byte_count));
          check_field("data_word", want.data_word, result.data_word);
          check_field("word_index", 16'(want.word_index), 16'(result.word_index));
          check_field("last", 16'(want.last), 16'(result.last));
        end
      end
    end
  end

  // hold off the receiver while bytes keep coming
  initial begin
    wait (bytes_accepted >= 150);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic push_byte(input logic [7:0] data, input logic start);
    rx_item_t it;
    it.data = data;
    it.start = start;
    rx_pending.push_back(it);
    items_queued++;
  endtask

  // fill < 0 randomizes the header and data bytes
  task automatic queue_frame(input logic [7:0] fc, input logic [15:0] regs, input int fill,
                             input int keep, input int trailing);
    logic [7:0] hb [0:12];
    int len;
    foreach (hb[i]) hb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    hb[7] = fc;
    hb[10] = regs[15:8];
    hb[11] = regs[7:0];
    if (fc == multi_code && fc != single_code)
      len = (regs == 0 || int'(regs) >= MAX_REGS) ? 13 : 13 + 2 * int'(regs);
    else
      len = 12;
    if (keep > 0 && keep < len) len = keep;
    for (int i = 0; i < len; i++) begin
      if (i < 13) push_byte(hb[i], i == 0);
      else push_byte((fill < 0) ? 8'($urandom) : 8'(fill), 1'b0);
    end
    repeat (trailing) push_byte(8'($urandom), 1'b0);
    frames_queued++;
  endtask

  task automatic random_traffic(input int n_items);
    int target;
    int sel;
    int r;
    int trailing;
    logic [15:0] regs;
    target = items_queued + n_items;
    while (items_queued < target) begin
      sel = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      if (r < 70) regs = 16'($urandom_range(1, 8));
      else if (r < 80) regs = 16'($urandom_range(9, 20));
      else if (r < 85) regs = 16'($urandom_range(21, MAX_REGS - 1));
      else if (r < 90) regs = 16'h0000;
      else if (r < 97) regs = 16'($urandom_range(MAX_REGS, 65535));
      else if (r < 98) regs = 16'(MAX_REGS);
      else regs = 16'(MAX_REGS - 1);
      trailing = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (sel < 55) begin
        queue_frame(multi_code, regs, -1, 0, trailing);
      end else if (sel < 70) begin
        queue_frame(single_code, regs, -1, 0, trailing);
      end else if (sel < 80) begin
        queue_frame(8'($urandom), regs, -1, 0, trailing);
      end else if (sel < 92) begin
        queue_frame($urandom_range(0, 1) ? multi_code : 8'($urandom), regs, -1,
                    $urandom_range(1, 20), 0);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic drain();
    while (rx_pending.size() != 0 || in_flight || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == mbtcp_pkg::REG_SINGLE_WRITE) single_code = val;
    else multi_code = val;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== {24'h0, val}) begin
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
               $time, idx, {24'h0, val}, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [7:0] sc;
    logic [7:0] mc;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_in.valid = 1'b0;
    byte_in.rx_byte = '0;
    byte_in.frame_start = 1'b0;
    result.ready = 1'b0;
    foreach (hdr[i]) hdr[i] = '0;
    send_gap_pct = 30;
    take_gap_pct = 30;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // ignored until the first frame start
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    queue_frame(8'hFF, 16'hFFFF, 8'hFF, 0, 0);
    queue_frame(single_code, 16'h0000, 8'h00, 0, 0);
    queue_frame(multi_code, 16'h0001, 8'hFF, 0, 0);
    queue_frame(multi_code, 16'h0002, 8'h00, 0, 0);
    queue_frame(multi_code, 16'h0000, 8'hA5, 0, 0);
    queue_frame(multi_code, 16'(MAX_REGS), -1, 0, 0);
    // drop a frame in mid-header
    queue_frame(multi_code, 16'h0003, -1, 5, 0);
    queue_frame(multi_code, 16'h0001, -1, 0, 2);
    random_traffic(ITEMS_PER_SETTING);

    for (int s = 1; s <= 4; s++) begin
      drain();
      case (s)
        1: begin
          sc = 8'h00;
          mc = 8'hFF;
        end
        2: begin
          sc = 8'h10;
          mc = 8'h10;
        end
        3: begin
          sc = 8'hFF;
          mc = 8'h00;
        end
        default: begin
          sc = 8'($urandom);
          mc = sc ^ 8'($urandom_range(1, 255));
        end
      endcase
      write_reg(mbtcp_pkg::REG_SINGLE_WRITE, sc);
      write_reg(mbtcp_pkg::REG_MULTI_WRITE, mc);
      send_gap_pct = (s == 1) ? 0 : $urandom_range(5, 60);
      take_gap_pct = (s == 1) ? 0 : $urandom_range(5, 60);
      random_traffic(ITEMS_PER_SETTING);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d headers and %0d data words from %0d bytes in %0d frames,",
             headers_checked, words_checked, bytes_accepted, frames_queued);
    $display("over five function code settings, with a long output stall and idle gaps.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
